// ===== sv/irpd_pkg.sv =====
// shared types and constants for the ir pulse-distance frame decoder
package irpd_pkg;

  localparam int unsigned FrameBits     = 28;
  localparam int unsigned CountWidth    = 5;
  localparam int unsigned TimeWidth     = 16;
  localparam int unsigned CmdWidth      = 8;
  localparam int unsigned ValueWidth    = 16;
  localparam int unsigned AddrWidth     = 4;
  localparam int unsigned OutDataWidth  = 32;
  localparam int unsigned ApbAddrWidth  = 3;
  localparam int unsigned ApbDataWidth  = 32;

  // 921 us at 6 ticks per us
  localparam logic [TimeWidth-1:0] ThresholdReset = 16'd5526;

  localparam logic [CountWidth-1:0] FrameCount = 5'd28;

  // register index taken from paddr[2]
  localparam logic RegLongThreshold = 1'b0;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_WAIT_FIRST = 2'd1,
    MODE_BITS       = 2'd2
  } mode_e;

endpackage

// ===== sv/ir_pulse_distance_frame_decoder_core.sv =====
// top level of the ir pulse-distance frame decoder
// a completing falling edge shows its frame in the cycle after acceptance
// throughput: one edge per cycle; s_axis_tready drops only while a frame waits unread
// decode state updates in the cycle an edge is accepted, frame held in one output register
// reset (async, active low): idle mode, last fall time zero, threshold 5526, no frame pending
module ir_pulse_distance_frame_decoder_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // edge requests
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [irpd_pkg::TimeWidth-1:0]        s_axis_tdata,  // [15:0] timestamp
  input  logic                                  s_axis_tuser,  // [0] edge_rising
  // frame results
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [irpd_pkg::OutDataWidth-1:0]     m_axis_tdata,  // command, data_value, address, pad
  // register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [irpd_pkg::ApbAddrWidth-1:0]     paddr,
  input  logic [irpd_pkg::ApbDataWidth-1:0]     pwdata,
  output logic [irpd_pkg::ApbDataWidth-1:0]     prdata,
  output logic                                  pready
);

  irpd_pkg::mode_e                      mode_q, mode_d;
  logic [irpd_pkg::TimeWidth-1:0]       last_fall_q, last_fall_d;
  logic [irpd_pkg::FrameBits-1:0]       shift_q, shift_d;
  logic [irpd_pkg::CountWidth-1:0]      count_q, count_d;
  logic [irpd_pkg::TimeWidth-1:0]       threshold_q;
  logic                                 out_valid_q, out_valid_d;
  logic [irpd_pkg::FrameBits-1:0]       out_frame_q, out_frame_d;

  logic                                 in_acc;
  logic                                 cfg_wr;
  logic [irpd_pkg::TimeWidth-1:0]       span;
  logic                                 is_long;
  logic [irpd_pkg::FrameBits-1:0]       shifted;
  logic [irpd_pkg::CountWidth-1:0]      count_inc;

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready
                         && (paddr[2] == irpd_pkg::RegLongThreshold);
  assign prdata        = (paddr[2] == irpd_pkg::RegLongThreshold)
                         ? {{(irpd_pkg::ApbDataWidth-irpd_pkg::TimeWidth){1'b0}}, threshold_q}
                         : '0;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign span      = s_axis_tdata - last_fall_q;
  assign is_long   = (span >= threshold_q);
  assign shifted   = {shift_q[irpd_pkg::FrameBits-2:0], is_long};
  assign count_inc = count_q + 5'd1;

  always_comb begin
    mode_d      = mode_q;
    last_fall_d = last_fall_q;
    shift_d     = shift_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_frame_d = out_frame_q;
    if (in_acc) begin
      if (s_axis_tuser) begin
        if (is_long) begin
          mode_d = irpd_pkg::MODE_WAIT_FIRST;
        end
      end else begin
        last_fall_d = s_axis_tdata;
        unique case (mode_q)
          irpd_pkg::MODE_WAIT_FIRST: begin
            shift_d = '0;
            count_d = '0;
            mode_d  = irpd_pkg::MODE_BITS;
          end
          irpd_pkg::MODE_BITS: begin
            shift_d = shifted;
            count_d = count_inc;
            if (count_inc == irpd_pkg::FrameCount) begin
              out_valid_d = 1'b1;
              out_frame_d = shifted;
              mode_d      = irpd_pkg::MODE_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= irpd_pkg::MODE_IDLE;
      last_fall_q <= '0;
      shift_q     <= '0;
      count_q     <= '0;
      threshold_q <= irpd_pkg::ThresholdReset;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      last_fall_q <= last_fall_d;
      shift_q     <= shift_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        threshold_q <= pwdata[irpd_pkg::TimeWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_frame_q <= out_frame_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    {(irpd_pkg::OutDataWidth-irpd_pkg::FrameBits){1'b0}},
    out_frame_q[irpd_pkg::AddrWidth-1:0],
    out_frame_q[irpd_pkg::AddrWidth +: irpd_pkg::ValueWidth],
    out_frame_q[irpd_pkg::FrameBits-1 -: irpd_pkg::CmdWidth]
  };

endmodule

// ===== sv/irpd_checker.sv =====
// port-level checker for the ir pulse-distance frame decoder and its bind
module irpd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [irpd_pkg::OutDataWidth-1:0]  m_axis_tdata,
  input logic                               pready
);

  // held frame stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("frame changed while stalled");

  // edges are taken whenever the output slot is free or draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output slot");

  // no frame without an accepted falling edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(s_axis_tvalid && s_axis_tready) || s_axis_tuser) && m_axis_tvalid && m_axis_tready
    |=> !m_axis_tvalid)
    else $error("frame appeared without a falling edge");

  // pad bits stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[irpd_pkg::OutDataWidth-1:irpd_pkg::FrameBits] == '0)
    else $error("padding bits set");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind ir_pulse_distance_frame_decoder_core irpd_checker u_irpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);
